// ----- sv/mcer_pkg.sv -----
// Shared types, constants and register codes for the multi-channel echo ranger.
// No dependencies; every other file of the block imports this package.
package mcer_pkg;

   localparam int CHANNELS          = 4;
   localparam int TIME_BITS_DEFAULT = 16;
   localparam int LEN_W             = 16;
   localparam int SCALE_W           = 16;
   localparam int TIMEOUT_W         = 16;
   localparam int DIST_W            = 24;
   localparam int DIST_SHIFT        = 8;
   localparam int PROD_W            = LEN_W + SCALE_W;
   localparam int CSR_W             = 16;
   localparam int CSR_IDX_W         = 2;
   localparam int TICK_W            = 4;

   localparam logic [CSR_IDX_W-1:0] CSR_CHANNEL_ENABLE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TIMEOUT_US     = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DISTANCE_SCALE = 2'd2;

   localparam logic [CHANNELS-1:0]  ENABLE_RESET  = 4'hF;
   localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 16'd30000;
   localparam logic [SCALE_W-1:0]   SCALE_RESET   = 16'd1114;

   localparam logic [TICK_W-1:0] TRIG_LOW_TICKS  = 4'd2;
   localparam logic [TICK_W-1:0] TRIG_HIGH_TICKS = 4'd10;

   typedef enum logic [1:0] {
      PH_IDLE,
      PH_TRIG_LOW,
      PH_TRIG_HIGH,
      PH_MEASURE
   } phase_type;

   typedef struct packed {
      logic             done;
      logic [LEN_W-1:0] length;
   } lane_status_type;

   typedef struct packed {
      logic                trigger;
      logic                complete;
      logic [CHANNELS-1:0] done_mask;
      logic                timed_out;
   } summary_type;

   typedef logic [CHANNELS-1:0][LEN_W-1:0]  length_vec_type;
   typedef logic [CHANNELS-1:0][DIST_W-1:0] distance_vec_type;

endpackage

// ----- sv/mcer_lane.sv -----
// One channel lane: echo edge detection, rise stamp, pulse length and done flag.
// Depends on mcer_pkg; instantiated once per channel by the top level.
module mcer_lane #(
   parameter int TIME_BITS = mcer_pkg::TIME_BITS_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     step,
   input  logic                     start,
   input  logic                     measure,
   input  logic                     enable,
   input  logic                     level,
   input  logic [TIME_BITS-1:0]     elapsed,
   output mcer_pkg::lane_status_type status
);
   import mcer_pkg::*;

   localparam int DIFF_W = (TIME_BITS > LEN_W) ? TIME_BITS : LEN_W;

   logic                 level_ff, level_in;
   logic                 seen_ff, seen_in;
   logic                 done_ff, done_in;
   logic [TIME_BITS-1:0] stamp_ff, stamp_in;
   logic [LEN_W-1:0]     length_ff, length_in;
   logic [TIME_BITS-1:0] span;
   logic [DIFF_W-1:0]    span_wide;

   always_comb begin
      level_in  = step ? level : level_ff;
      seen_in   = seen_ff;
      done_in   = done_ff;
      stamp_in  = stamp_ff;
      length_in = length_ff;
      span      = elapsed - stamp_ff;
      span_wide = DIFF_W'(span);
      if (start) begin
         seen_in   = 1'b0;
         done_in   = 1'b0;
         stamp_in  = '0;
         length_in = '0;
      end else if (measure && enable) begin
         if (level && !level_ff) begin
            stamp_in = elapsed;
            seen_in  = 1'b1;
         end else if (!level && level_ff && seen_ff) begin
            length_in = span_wide[LEN_W-1:0];
            done_in   = 1'b1;
         end
      end
      status.done   = done_in;
      status.length = length_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff <= 1'b0;
         seen_ff  <= 1'b0;
         done_ff  <= 1'b0;
      end else begin
         level_ff <= level_in;
         seen_ff  <= seen_in;
         done_ff  <= done_in;
      end
      stamp_ff  <= stamp_in;
      length_ff <= length_in;
   end

endmodule

// ----- sv/mcer_merge.sv -----
// Merging stage: registers the lane findings, scales each length, holds the result item.
// Depends on mcer_pkg; instantiated by the top level.
module mcer_merge (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       in_valid,
   output logic                       in_ready,
   input  mcer_pkg::summary_type      in_summary,
   input  mcer_pkg::length_vec_type   in_length,
   input  logic [mcer_pkg::SCALE_W-1:0] scale,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output mcer_pkg::summary_type      rsp_summary,
   output mcer_pkg::distance_vec_type rsp_distance
);
   import mcer_pkg::*;

   logic             s1_valid_ff, s1_valid_in;
   summary_type      s1_summary_ff, s1_summary_in;
   length_vec_type   s1_length_ff, s1_length_in;
   logic             out_valid_ff, out_valid_in;
   summary_type      out_summary_ff, out_summary_in;
   distance_vec_type out_distance_ff, out_distance_in;
   logic             out_load;
   logic             take;
   logic [PROD_W-1:0] product [CHANNELS];

   always_comb begin
      out_load        = s1_valid_ff && (!out_valid_ff || rsp_ready);
      in_ready        = !s1_valid_ff || out_load;
      take            = in_valid && in_ready;
      s1_valid_in     = take ? 1'b1 : (out_load ? 1'b0 : s1_valid_ff);
      s1_summary_in   = take ? in_summary : s1_summary_ff;
      s1_length_in    = take ? in_length : s1_length_ff;
      out_valid_in    = out_load ? 1'b1 : (rsp_ready ? 1'b0 : out_valid_ff);
      out_summary_in  = out_load ? s1_summary_ff : out_summary_ff;
      out_distance_in = out_distance_ff;
      for (int i = 0; i < CHANNELS; i++) begin
         product[i] = PROD_W'(s1_length_ff[i]) * PROD_W'(scale);
         if (out_load) begin
            out_distance_in[i] = product[i][DIST_SHIFT +: DIST_W];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
      s1_summary_ff   <= s1_summary_in;
      s1_length_ff    <= s1_length_in;
      out_summary_ff  <= out_summary_in;
      out_distance_ff <= out_distance_in;
   end

   assign rsp_valid    = out_valid_ff;
   assign rsp_summary  = out_summary_ff;
   assign rsp_distance = out_distance_ff;

endmodule

// ----- sv/multi_channel_echo_ranger.sv -----
// Multi-channel echo ranger: trigger sequencer, channel lanes and merging stage.
// Results pass the merging stage's input and output registers. Throughput: one item
// per cycle while results are taken; the sequencer and lanes update in the accept
// cycle, the merging stage scales all lengths with one 16x16 multiplier per lane.
// Reset (synchronous): idle phase, counters and lane flags cleared, registers at
// their defaults (enable 15, timeout 30000, scale 1114), no result pending.
module multi_channel_echo_ranger #(
   parameter int TIME_BITS = mcer_pkg::TIME_BITS_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic                            req_operation,
   input  logic [mcer_pkg::CHANNELS-1:0]   req_echo_levels,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic                            rsp_trigger,
   output logic                            rsp_complete,
   output logic [mcer_pkg::CHANNELS-1:0]   rsp_done_mask,
   output logic                            rsp_timed_out,
   output logic [mcer_pkg::DIST_W-1:0]     rsp_distance_0,
   output logic [mcer_pkg::DIST_W-1:0]     rsp_distance_1,
   output logic [mcer_pkg::DIST_W-1:0]     rsp_distance_2,
   output logic [mcer_pkg::DIST_W-1:0]     rsp_distance_3,
   input  logic                            csr_write_en,
   input  logic [mcer_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [mcer_pkg::CSR_W-1:0]      csr_write_data
);
   import mcer_pkg::*;

   localparam int CMP_W = (TIME_BITS > TIMEOUT_W) ? TIME_BITS : TIMEOUT_W;
   localparam logic [TIME_BITS-1:0] TIME_MAX = {TIME_BITS{1'b1}};

   logic [CHANNELS-1:0]  channel_enable_ff, channel_enable_in;
   logic [TIMEOUT_W-1:0] timeout_ff, timeout_in;
   logic [SCALE_W-1:0]   scale_ff, scale_in;

   phase_type            phase_ff, phase_in, phase_eff;
   logic [TICK_W-1:0]    ticks_ff, ticks_in, ticks_eff, ticks_step;
   logic [TIME_BITS-1:0] elapsed_ff, elapsed_in, elapsed_eff, elapsed_step;

   logic                 accept;
   logic                 start;
   logic                 measure;
   logic                 all_done;
   logic                 expired;
   logic                 finish;
   logic                 trigger;
   lane_status_type      lane_status [CHANNELS];
   summary_type          summary;
   length_vec_type       lengths;
   summary_type          rsp_summary;
   distance_vec_type     rsp_distance;

   always_comb begin
      channel_enable_in = channel_enable_ff;
      timeout_in        = timeout_ff;
      scale_in          = scale_ff;
      if (csr_write_en) begin
         unique case (csr_index)
            CSR_CHANNEL_ENABLE: channel_enable_in = csr_write_data[CHANNELS-1:0];
            CSR_TIMEOUT_US:     timeout_in        = csr_write_data[TIMEOUT_W-1:0];
            CSR_DISTANCE_SCALE: scale_in          = csr_write_data[SCALE_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         channel_enable_ff <= ENABLE_RESET;
         timeout_ff        <= TIMEOUT_RESET;
         scale_ff          <= SCALE_RESET;
      end else begin
         channel_enable_ff <= channel_enable_in;
         timeout_ff        <= timeout_in;
         scale_ff          <= scale_in;
      end
   end

   always_comb begin
      accept       = req_valid && req_ready;
      start        = accept && req_operation;
      phase_eff    = req_operation ? PH_TRIG_LOW : phase_ff;
      ticks_eff    = req_operation ? '0 : ticks_ff;
      elapsed_eff  = req_operation ? '0 : elapsed_ff;
      ticks_step   = ticks_eff + TICK_W'(1);
      elapsed_step = (elapsed_eff != TIME_MAX) ? elapsed_eff + TIME_BITS'(1) : elapsed_eff;
      measure      = accept && (phase_eff == PH_MEASURE);
      all_done     = 1'b1;
      for (int i = 0; i < CHANNELS; i++) begin
         if (channel_enable_ff[i] && !lane_status[i].done) begin
            all_done = 1'b0;
         end
      end
      expired  = (CMP_W'(elapsed_step) >= CMP_W'(timeout_ff)) || (elapsed_step == TIME_MAX);
      finish   = 1'b0;
      trigger  = 1'b0;
      phase_in   = phase_ff;
      ticks_in   = ticks_ff;
      elapsed_in = elapsed_ff;
      if (accept) begin
         phase_in   = phase_eff;
         ticks_in   = ticks_eff;
         elapsed_in = elapsed_eff;
         unique case (phase_eff)
            PH_IDLE: ;
            PH_TRIG_LOW: begin
               ticks_in = ticks_step;
               if (ticks_step >= TRIG_LOW_TICKS) begin
                  phase_in = PH_TRIG_HIGH;
                  ticks_in = '0;
               end
            end
            PH_TRIG_HIGH: begin
               trigger  = 1'b1;
               ticks_in = ticks_step;
               if (ticks_step >= TRIG_HIGH_TICKS) begin
                  phase_in   = PH_MEASURE;
                  ticks_in   = '0;
                  elapsed_in = '0;
               end
            end
            PH_MEASURE: begin
               elapsed_in = elapsed_step;
               if (all_done || expired) begin
                  finish   = 1'b1;
                  phase_in = PH_IDLE;
               end
            end
         endcase
      end
      summary.trigger   = trigger;
      summary.complete  = finish;
      summary.timed_out = finish && !all_done;
      for (int i = 0; i < CHANNELS; i++) begin
         summary.done_mask[i] = finish && lane_status[i].done;
         lengths[i] = summary.done_mask[i] ? lane_status[i].length : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_IDLE;
         ticks_ff   <= '0;
         elapsed_ff <= '0;
      end else begin
         phase_ff   <= phase_in;
         ticks_ff   <= ticks_in;
         elapsed_ff <= elapsed_in;
      end
   end

   for (genvar g = 0; g < CHANNELS; g++) begin : g_lane
      mcer_lane #(
         .TIME_BITS(TIME_BITS)
      ) u_lane (
         .clock   (clock),
         .reset   (reset),
         .step    (accept),
         .start   (start),
         .measure (measure),
         .enable  (channel_enable_ff[g]),
         .level   (req_echo_levels[g]),
         .elapsed (elapsed_step),
         .status  (lane_status[g])
      );
   end

   mcer_merge u_merge (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (req_valid),
      .in_ready     (req_ready),
      .in_summary   (summary),
      .in_length    (lengths),
      .scale        (scale_ff),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_summary  (rsp_summary),
      .rsp_distance (rsp_distance)
   );

   assign rsp_trigger    = rsp_summary.trigger;
   assign rsp_complete   = rsp_summary.complete;
   assign rsp_done_mask  = rsp_summary.done_mask;
   assign rsp_timed_out  = rsp_summary.timed_out;
   assign rsp_distance_0 = rsp_distance[0];
   assign rsp_distance_1 = rsp_distance[1];
   assign rsp_distance_2 = rsp_distance[2];
   assign rsp_distance_3 = rsp_distance[3];

   a_idle_result_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_complete |-> rsp_done_mask == '0 && !rsp_timed_out
         && rsp_distance_0 == '0 && rsp_distance_1 == '0
         && rsp_distance_2 == '0 && rsp_distance_3 == '0)
      else $error("result without completion carries measurements");

   a_all_done_covers_enabled: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_complete && !rsp_timed_out
         |-> (rsp_done_mask | ~channel_enable_ff) == {CHANNELS{1'b1}})
      else $error("completion without timeout leaves an enabled channel unmeasured");

   a_tick_count_bound: assert property (@(posedge clock) disable iff (reset)
      ticks_ff < TRIG_HIGH_TICKS && (phase_ff != PH_IDLE || ticks_ff == '0))
      else $error("trigger tick counter out of range");

   a_idle_elapsed_hold: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_IDLE && !(req_valid && req_ready) |=> $stable(elapsed_ff))
      else $error("elapsed counter moved while idle");

endmodule

// ----- tb/multi_channel_echo_ranger_test.sv -----
`timescale 1ns / 1ps
// Self-checking bench for multi_channel_echo_ranger: a tick-accurate ranging predictor in a
// scoreboard class, random handshake idling, receiver back-pressure and register sweeps.
// Depends on mcer_pkg and the ranger RTL only.
module multi_channel_echo_ranger_test;
   import mcer_pkg::*;

   localparam int CYCLE_LIMIT   = 1_000_000;
   localparam int RANDOM_ITEMS  = 1650;
   localparam int SETTLE_CYCLES = 8;
   localparam int RX_HOLD       = 400;
   localparam int NEVER         = 1 << 30;
   localparam logic [TIME_BITS_DEFAULT-1:0] TIME_FULL = '1;

   typedef struct packed {
      summary_type      summary;
      distance_vec_type distance;
   } ranging_result_type;

   class echo_ranging_scoreboard;
      logic [CHANNELS-1:0]          enable_mask;
      logic [TIMEOUT_W-1:0]         timeout_ticks;
      logic [SCALE_W-1:0]           scale;
      phase_type                    phase;
      logic [TICK_W-1:0]            phase_ticks;
      logic [TIME_BITS_DEFAULT-1:0] elapsed;
      logic [CHANNELS-1:0]          echo_prev;
      logic [CHANNELS-1:0]          rise_seen;
      logic [CHANNELS-1:0]          channel_done;
      length_vec_type               rise_stamp;
      length_vec_type               pulse_len;
      ranging_result_type           results_due[$];
      int                           errors;

      function new();
         enable_mask   = ENABLE_RESET;
         timeout_ticks = TIMEOUT_RESET;
         scale         = SCALE_RESET;
         phase         = PH_IDLE;
         phase_ticks   = '0;
         elapsed       = '0;
         echo_prev     = '0;
         rise_seen     = '0;
         channel_done  = '0;
         rise_stamp    = '0;
         pulse_len     = '0;
         errors        = 0;
      endfunction

      function void configure(logic [CSR_IDX_W-1:0] idx, logic [CSR_W-1:0] data);
         case (idx)
            CSR_CHANNEL_ENABLE: enable_mask = data[CHANNELS-1:0];
            CSR_TIMEOUT_US: timeout_ticks = data[TIMEOUT_W-1:0];
            CSR_DISTANCE_SCALE: scale = data[SCALE_W-1:0];
            default: ;
         endcase
      endfunction

      function void predict_tick(logic op, logic [CHANNELS-1:0] levels);
         ranging_result_type r;
         logic               all_done;
         logic               expired;
         logic [PROD_W-1:0]  product;
         r = '0;
         if (op) begin
            rise_seen    = '0;
            channel_done = '0;
            rise_stamp   = '0;
            pulse_len    = '0;
            phase        = PH_TRIG_LOW;
            phase_ticks  = '0;
            elapsed      = '0;
         end
         case (phase)
            PH_TRIG_LOW: begin
               phase_ticks = phase_ticks + 1'b1;
               if (phase_ticks >= TRIG_LOW_TICKS) begin
                  phase       = PH_TRIG_HIGH;
                  phase_ticks = '0;
               end
            end
            PH_TRIG_HIGH: begin
               r.summary.trigger = 1'b1;
               phase_ticks = phase_ticks + 1'b1;
               if (phase_ticks >= TRIG_HIGH_TICKS) begin
                  phase       = PH_MEASURE;
                  phase_ticks = '0;
                  elapsed     = '0;
               end
            end
            PH_MEASURE: begin
               all_done = 1'b1;
               if (elapsed != TIME_FULL) elapsed = elapsed + 1'b1;
               for (int c = 0; c < CHANNELS; c++) begin
                  if (enable_mask[c]) begin
                     if (levels[c] && !echo_prev[c]) begin
                        rise_stamp[c] = elapsed;
                        rise_seen[c]  = 1'b1;
                     end else if (!levels[c] && echo_prev[c] && rise_seen[c]) begin
                        pulse_len[c]    = elapsed - rise_stamp[c];
                        channel_done[c] = 1'b1;
                     end
                     if (!channel_done[c]) all_done = 1'b0;
                  end
               end
               expired = (elapsed >= timeout_ticks) || (elapsed == TIME_FULL);
               if (all_done || expired) begin
                  r.summary.complete  = 1'b1;
                  r.summary.timed_out = !all_done;
                  for (int c = 0; c < CHANNELS; c++) begin
                     if (channel_done[c]) begin
                        product               = pulse_len[c] * scale;
                        r.summary.done_mask[c] = 1'b1;
                        r.distance[c]         = product[DIST_SHIFT +: DIST_W];
                     end
                  end
                  phase = PH_IDLE;
               end
            end
            default: ;
         endcase
         echo_prev = levels;
         results_due.push_back(r);
      endfunction

      task report(string what);
         $display("mismatch: %s", what);
         errors++;
      endtask

      task check_result(ranging_result_type got);
         ranging_result_type want;
         if (results_due.size() == 0) begin
            report("result item with no item outstanding");
            return;
         end
         want = results_due.pop_front();
         if (got.summary.trigger !== want.summary.trigger)
            report($sformatf("trigger got %0b want %0b",
                             got.summary.trigger, want.summary.trigger));
         if (got.summary.complete !== want.summary.complete)
            report($sformatf("complete got %0b want %0b",
                             got.summary.complete, want.summary.complete));
         if (got.summary.done_mask !== want.summary.done_mask)
            report($sformatf("done_mask got %h want %h",
                             got.summary.done_mask, want.summary.done_mask));
         if (got.summary.timed_out !== want.summary.timed_out)
            report($sformatf("timed_out got %0b want %0b",
                             got.summary.timed_out, want.summary.timed_out));
         for (int c = 0; c < CHANNELS; c++)
            if (got.distance[c] !== want.distance[c])
               report($sformatf("distance_%0d got %0d want %0d",
                                c, got.distance[c], want.distance[c]));
      endtask
   endclass

   logic                 clock;
   logic                 reset           = 1'b1;
   logic                 req_valid       = 1'b0;
   logic                 req_ready;
   logic                 req_operation   = 1'b0;
   logic [CHANNELS-1:0]  req_echo_levels = '0;
   logic                 rsp_valid;
   logic                 rsp_ready       = 1'b0;
   logic                 rsp_trigger;
   logic                 rsp_complete;
   logic [CHANNELS-1:0]  rsp_done_mask;
   logic                 rsp_timed_out;
   logic [DIST_W-1:0]    rsp_distance_0;
   logic [DIST_W-1:0]    rsp_distance_1;
   logic [DIST_W-1:0]    rsp_distance_2;
   logic [DIST_W-1:0]    rsp_distance_3;
   logic                 csr_write_en    = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index       = '0;
   logic [CSR_W-1:0]     csr_write_data  = '0;

   echo_ranging_scoreboard sb;
   bit idling        = 1'b1;
   bit hold_receiver = 1'b0;
   int items_sent    = 0;
   int cycle_count   = 0;
   int echo_rise[CHANNELS];
   int echo_fall[CHANNELS];

   multi_channel_echo_ranger dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_operation   (req_operation),
      .req_echo_levels (req_echo_levels),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_trigger     (rsp_trigger),
      .rsp_complete    (rsp_complete),
      .rsp_done_mask   (rsp_done_mask),
      .rsp_timed_out   (rsp_timed_out),
      .rsp_distance_0  (rsp_distance_0),
      .rsp_distance_1  (rsp_distance_1),
      .rsp_distance_2  (rsp_distance_2),
      .rsp_distance_3  (rsp_distance_3),
      .csr_write_en    (csr_write_en),
      .csr_index       (csr_index),
      .csr_write_data  (csr_write_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   always @(posedge clock) begin
      ranging_result_type got;
      if (!reset && rsp_valid && rsp_ready) begin
         got = {rsp_trigger, rsp_complete, rsp_done_mask, rsp_timed_out,
                rsp_distance_3, rsp_distance_2, rsp_distance_1, rsp_distance_0};
         sb.check_result(got);
      end
   end

   initial begin
      int stall;
      do @(posedge clock); while (reset);
      forever begin
         if (hold_receiver) begin
            hold_receiver = 1'b0;
            rsp_ready <= 1'b0;
            repeat (RX_HOLD) @(posedge clock);
         end
         stall = idling ? $urandom_range(0, 15) : 0;
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   task automatic send_item(input logic op, input logic [CHANNELS-1:0] levels);
      int gap;
      gap = idling ? $urandom_range(0, 15) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_operation   <= op;
      req_echo_levels <= levels;
      do @(posedge clock); while (!req_ready);
      sb.predict_tick(op, levels);
      items_sent++;
   endtask

   task automatic play_reading(input int ticks, input bit noisy);
      logic [CHANNELS-1:0] levels;
      for (int k = 0; k < ticks; k++) begin
         for (int c = 0; c < CHANNELS; c++)
            levels[c] = (k >= echo_rise[c]) && (k < echo_fall[c]);
         if (noisy) levels = CHANNELS'($urandom);
         send_item(k == 0, levels);
      end
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (sb.results_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_W-1:0] data);
      csr_write_en   <= 1'b1;
      csr_index      <= idx;
      csr_write_data <= data;
      @(posedge clock);
      sb.configure(idx, data);
   endtask

   task automatic write_config(input logic [CHANNELS-1:0] en, input logic [TIMEOUT_W-1:0] tmo,
                               input logic [SCALE_W-1:0] scl);
      logic [CSR_W-1:0] en_word;
      en_word                 = CSR_W'($urandom);
      en_word[CHANNELS-1:0]   = en;
      write_reg(CSR_CHANNEL_ENABLE, en_word);
      write_reg(CSR_TIMEOUT_US, tmo);
      write_reg(CSR_DISTANCE_SCALE, scl);
      csr_write_en <= 1'b0;
   endtask

   initial begin
      int                   random_base;
      int                   span;
      int                   ticks;
      int                   phase_count;
      logic [CHANNELS-1:0]  en;
      logic [TIMEOUT_W-1:0] tmo;
      logic [SCALE_W-1:0]   scl;
      sb = new();
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset defaults: idle tick, reading cut short in measuring, then a full reading
      send_item(1'b0, '1);
      echo_rise = '{0, 0, 0, 0};
      echo_fall = '{20, 20, 20, 20};
      play_reading(14, 1'b0);
      echo_rise = '{12, 13, 14, 15};
      echo_fall = '{14, 20, 15, 30};
      play_reading(32, 1'b0);
      drain();

      // no channel enabled
      write_config('0, 16'd1, '0);
      echo_rise = '{NEVER, NEVER, NEVER, NEVER};
      echo_fall = '{NEVER, NEVER, NEVER, NEVER};
      play_reading(14, 1'b0);
      drain();

      // all done on the timeout tick, then a fall with no rise and a timeout
      write_config('1, 16'd3, '1);
      echo_rise = '{12, 12, 12, 12};
      echo_fall = '{14, 14, 14, 14};
      play_reading(16, 1'b0);
      echo_rise = '{8, 12, 12, NEVER};
      echo_fall = '{14, 13, 13, NEVER};
      play_reading(16, 1'b0);
      drain();

      random_base = items_sent;
      phase_count = 0;
      while (items_sent - random_base < RANDOM_ITEMS) begin
         drain();
         idling = ($urandom_range(0, 3) != 0);
         case ($urandom_range(0, 5))
            0: en = '0;
            1: en = '1;
            default: en = CHANNELS'($urandom);
         endcase
         case ($urandom_range(0, 7))
            0: tmo = 16'd1;
            1: tmo = TIMEOUT_W'($urandom_range(100, 400));
            default: tmo = TIMEOUT_W'($urandom_range(2, 40));
         endcase
         case ($urandom_range(0, 5))
            0: scl = '0;
            1: scl = '1;
            default: scl = SCALE_W'($urandom);
         endcase
         write_config(en, tmo, scl);
         if (phase_count == 2) hold_receiver = 1'b1;
         repeat ($urandom_range(3, 8)) begin
            span = (tmo < 200) ? int'(tmo) : 200;
            for (int c = 0; c < CHANNELS; c++) begin
               echo_rise[c] = $urandom_range(0, span + 11);
               echo_fall[c] = echo_rise[c] + $urandom_range(1, span);
               if ($urandom_range(0, 5) == 0) echo_rise[c] = NEVER;
            end
            ticks = 12 + span + $urandom_range(0, 4);
            if ($urandom_range(0, 9) == 0) ticks = $urandom_range(1, ticks);
            play_reading(ticks, $urandom_range(0, 9) == 0);
         end
         phase_count++;
      end

      drain();
      if (sb.errors == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
sv/mcer_pkg.sv
sv/mcer_lane.sv
sv/mcer_merge.sv
sv/multi_channel_echo_ranger.sv
tb/multi_channel_echo_ranger_test.sv
